// ===== rtl/alrf_pkg.sv =====
// Shared types and constants for the absolute-loader record framer.
// Holds the request, result and internal job formats used by the modules.
// No dependencies.
package alrf_pkg;

	// Command codes carried in the command field of a request.
	localparam logic CMD_START = 1'b0;
	localparam logic CMD_DATA  = 1'b1;

	// Fixed header bytes and the header length added to the data length.
	localparam logic [7:0]  HDR_BYTE0   = 8'h01;
	localparam logic [7:0]  HDR_BYTE1   = 8'h00;
	localparam logic [15:0] HDR_LENGTH  = 16'd6;

	// Default depth of the job queue between front and back.
	localparam int JOB_DEPTH_DEFAULT = 4;

	// Position of each byte within a header job, and within a data job.
	localparam logic [2:0] STEP_BYTE0  = 3'd0;
	localparam logic [2:0] STEP_BYTE1  = 3'd1;
	localparam logic [2:0] STEP_LEN_LO = 3'd2;
	localparam logic [2:0] STEP_LEN_HI = 3'd3;
	localparam logic [2:0] STEP_ADR_LO = 3'd4;
	localparam logic [2:0] STEP_ADR_HI = 3'd5;
	localparam logic [2:0] STEP_CHECK  = 3'd6;
	localparam logic [2:0] STEP_DATA   = 3'd0;
	localparam logic [2:0] STEP_DCHECK = 3'd1;

	typedef struct packed {
		logic        command;
		logic [15:0] load_address;
		logic [15:0] data_length;
		logic [7:0]  data_byte;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       record_end;
	} out_item_t;

	typedef enum logic {
		JOB_HEADER = 1'b0,
		JOB_DATA   = 1'b1
	} job_kind_t;

	// One unit of work for the back end: a header or a data byte,
	// optionally followed by the closing checksum.
	typedef struct packed {
		job_kind_t   kind;
		logic        close;
		logic [7:0]  checksum;
		logic [7:0]  data_byte;
		logic [15:0] rec_len;
		logic [15:0] load_address;
	} job_t;

endpackage

// ===== rtl/absolute_loader_record_framer.sv =====
// Absolute-loader record framer, top level.
// Depends on alrf_pkg, alrf_front, alrf_fifo and alrf_back.
//
// Usage: requests enter through a queue-style port (push, full, item) and
// framed bytes leave through another (empty, pop, result). A request is
// taken on a rising edge with push high and full low; the result byte on
// the result port is taken on a rising edge with pop high and empty low.
// A start request produces the six header bytes, plus the checksum byte
// when its data length is zero. A data request produces its byte, plus
// the checksum (record_end high) when it completes the record; data with
// no record open produces nothing.
// When the back end is otherwise idle, the first byte of a request is
// registered in the job queue and then in the result register.
// Throughput: one request per cycle while the job queue has room; the back
// end emits one byte per cycle while the receiver pops; a header job
// yields six or seven bytes and a data job one or two. The job queue
// between front and back (JOB_DEPTH entries) absorbs requests meanwhile.
// Reset clears the record state, the queue and the result-valid flag.
// When the receiver stalls, the result holds, the queue fills, and full
// rises to hold off further requests.
module absolute_loader_record_framer
	import alrf_pkg::*;
#(
	parameter int JOB_DEPTH = JOB_DEPTH_DEFAULT
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	output logic      full,
	input  in_item_t  item,
	output logic      empty,
	input  logic      pop,
	output out_item_t result
);

	logic accept;
	logic job_valid;
	job_t front_job;
	logic job_avail;
	job_t head_job;
	logic job_done;

	assign accept = push && !full;

	// Request classification and record state.
	alrf_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.item      (item),
		.job_valid (job_valid),
		.job       (front_job)
	);

	// Job queue decoupling the two ends.
	alrf_fifo #(
		.DEPTH (JOB_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (job_valid),
		.wr_job (front_job),
		.rd_en  (job_done),
		.full   (full),
		.avail  (job_avail),
		.rd_job (head_job)
	);

	// Byte serialiser and result register.
	alrf_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_avail (job_avail),
		.job       (head_job),
		.job_done  (job_done),
		.pop       (pop),
		.empty     (empty),
		.result    (result)
	);

endmodule

// ===== rtl/alrf_front.sv =====
// Front end of the record framer: accepts requests, tracks the open record
// and turns each request into at most one job for the back end.
// Depends on alrf_pkg.
module alrf_front
	import alrf_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     accept,
	input  in_item_t item,
	output logic     job_valid,
	output job_t     job
);

	logic [15:0] remaining_q;
	logic [7:0]  sum_q;
	logic        open_q;

	logic [15:0] rec_len;
	logic [7:0]  hdr_sum;
	logic [7:0]  data_sum;
	logic        start_zero;
	logic        data_live;
	logic        data_last;

	// Record length (data length plus header length) and the sum of the six header bytes.
	assign rec_len  = item.data_length + HDR_LENGTH;
	assign hdr_sum  = HDR_BYTE0 + HDR_BYTE1 + rec_len[7:0] + rec_len[15:8]
		+ item.load_address[7:0] + item.load_address[15:8];
	assign data_sum = sum_q + item.data_byte;

	assign start_zero = (item.data_length == 16'd0);
	assign data_live  = open_q && (remaining_q != 16'd0);
	assign data_last  = (remaining_q == 16'd1);

	// Classify the request and build the job; stray data makes no job.
	always_comb begin
		job              = '0;
		job.rec_len      = rec_len;
		job.load_address = item.load_address;
		job.data_byte    = item.data_byte;
		job_valid        = 1'b0;
		if (item.command == CMD_START) begin
			job.kind     = JOB_HEADER;
			job.close    = start_zero;
			job.checksum = 8'd0 - hdr_sum;
			job_valid    = accept;
		end else begin
			job.kind     = JOB_DATA;
			job.close    = data_last;
			job.checksum = 8'd0 - data_sum;
			job_valid    = accept && data_live;
		end
	end

	// Record state, updated for each accepted start and each accepted data request in an open record.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			remaining_q <= '0;
			sum_q       <= '0;
			open_q      <= 1'b0;
		end else if (accept) begin
			if (item.command == CMD_START) begin
				remaining_q <= item.data_length;
				sum_q       <= start_zero ? 8'd0 : hdr_sum;
				open_q      <= !start_zero;
			end else if (data_live) begin
				remaining_q <= remaining_q - 16'd1;
				sum_q       <= data_last ? 8'd0 : data_sum;
				open_q      <= !data_last;
			end
		end
	end

endmodule

// ===== rtl/alrf_fifo.sv =====
// Short job queue between the front and back ends of the record framer.
// Register-based, one write and one read per cycle. Depends on alrf_pkg.
module alrf_fifo
	import alrf_pkg::*;
#(
	parameter int DEPTH = JOB_DEPTH_DEFAULT
) (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  job_t wr_job,
	input  logic rd_en,
	output logic full,
	output logic avail,
	output job_t rd_job
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	job_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full   = (count_q == CNT_W'(DEPTH));
	assign avail  = (count_q != '0);
	assign rd_job = mem_q[rd_ptr_q];

	// Storage is written at the tail only.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_job;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/alrf_back.sv =====
// Back end of the record framer: expands each queued job into its bytes,
// one per cycle unless stalled, into the result register. Needs alrf_pkg.
module alrf_back
	import alrf_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      job_avail,
	input  job_t      job,
	output logic      job_done,
	input  logic      pop,
	output logic      empty,
	output out_item_t result
);

	logic [2:0] step_q;
	logic       out_valid_q;
	out_item_t  out_q;

	logic       load;
	logic [2:0] last_step;
	logic       at_last;
	logic [7:0] next_byte;

	// A new byte moves into the result register when it is free or drained.
	assign load    = job_avail && (!out_valid_q || pop);
	assign at_last = (step_q == last_step);
	assign job_done = load && at_last;

	assign empty  = !out_valid_q;
	assign result = out_q;

	// Byte selection for the current step of the job.
	always_comb begin
		next_byte = job.checksum;
		last_step = STEP_DATA;
		unique case (job.kind)
			JOB_HEADER: begin
				last_step = job.close ? STEP_CHECK : STEP_ADR_HI;
				unique case (step_q)
					STEP_BYTE0:  next_byte = HDR_BYTE0;
					STEP_BYTE1:  next_byte = HDR_BYTE1;
					STEP_LEN_LO: next_byte = job.rec_len[7:0];
					STEP_LEN_HI: next_byte = job.rec_len[15:8];
					STEP_ADR_LO: next_byte = job.load_address[7:0];
					STEP_ADR_HI: next_byte = job.load_address[15:8];
					default:     next_byte = job.checksum;
				endcase
			end
			JOB_DATA: begin
				last_step = job.close ? STEP_DCHECK : STEP_DATA;
				next_byte = (step_q == STEP_DATA) ? job.data_byte : job.checksum;
			end
			default: begin
				last_step = STEP_DATA;
				next_byte = job.checksum;
			end
		endcase
	end

	// Step counter and result-valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				step_q      <= at_last ? 3'd0 : step_q + 3'd1;
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (load) begin
			out_q.out_byte   <= next_byte;
			out_q.record_end <= at_last && job.close;
		end
	end

	// The step counter never runs past the checksum of a header.
	a_step_bound: assert property (@(posedge clk) disable iff (!arst_n)
		step_q <= STEP_CHECK)
		else $error("alrf_back: step counter out of range");

	// A job is only retired while one is waiting.
	a_done_avail: assert property (@(posedge clk) disable iff (!arst_n)
		job_done |-> job_avail)
		else $error("alrf_back: job retired from an empty queue");

	// A job part-way through stays at the head of the queue.
	a_mid_job: assert property (@(posedge clk) disable iff (!arst_n)
		step_q != 3'd0 |-> job_avail)
		else $error("alrf_back: job lost while being expanded");

	// A result held back by the receiver does not change.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !pop |=> out_valid_q && $stable(out_q))
		else $error("alrf_back: stalled result changed");

endmodule
